[sv/mbs_pkg.sv]
// Shared constants, codes and handshake structs for the metronome beat scheduler.
package mbs_pkg;

  // Tempo limits and reset values
  localparam logic [7:0]  TEMPO_MIN     = 8'd40;
  localparam logic [7:0]  TEMPO_MAX     = 8'd240;
  localparam logic [7:0]  TEMPO_RESET   = 8'd120;
  localparam logic [31:0] MS_PER_MINUTE = 32'd60000;
  localparam logic [15:0] FLASH_RESET   = 16'd140;
  localparam logic [15:0] REPAINT_RESET = 16'd33;

  // Divider widths: 32-bit dividend, divisor up to the longest period
  localparam int DIV_W = 32;
  localparam int PER_W = 11;
  localparam int CNT_W = $clog2(DIV_W);

  // Event kinds
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_TOGGLE  = 3'd1;
  localparam logic [2:0] KIND_TEMPO   = 3'd2;
  localparam logic [2:0] KIND_LEAVE   = 3'd3;
  localparam logic [2:0] KIND_REPAINT = 3'd4;

  // Configuration register indexes
  localparam logic CFG_FLASH   = 1'b0;
  localparam logic CFG_REPAINT = 1'b1;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [PER_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [PER_W-1:0] remainder;
  } div_rsp_t;

endpackage

[sv/metronome_beat_scheduler.sv]
// Metronome beat scheduler: event sequencer, tempo/beat state and result register.
//
// Usage: events enter on the in_ channel (valid/ready) with a kind, a 32-bit
// millisecond timestamp and a signed tempo delta. Each event gives exactly one
// result on the out_ channel (valid/ready): beat, wants_repaint, running and
// tempo_bpm, all taken after the event is applied.
// Two configuration registers (flash length, repaint interval): the user writes
// them via cfg_we/cfg_index/cfg_wdata only while the block is idle (unenforced).
// Sequencing: toggle, leave, repaint done, unused kinds and ticks without a
// catch-up go from the idle state straight to the emit state, which loads the
// result register. A tempo adjust while running first runs one period division;
// a tick that catches up runs a period division, then a remainder division.
// Both run on one shared 1-bit-per-cycle divider of 32 steps. One event is
// in flight at a time; in_ready is high only while the sequencer is idle.
// Reset (rst_n low, synchronous) sets tempo 120, stopped, next-beat, flash-end
// and last-repaint times 0, the registers to 140 and 33 ms. A stalled receiver
// holds the result in the output register; the sequencer waits until it is taken.
module metronome_beat_scheduler
  import mbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_kind,
  input  logic [31:0]       in_now_ms,
  input  logic signed [8:0] in_tempo_delta,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_beat,
  output logic              out_wants_repaint,
  output logic              out_running,
  output logic [7:0]        out_tempo_bpm,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_wdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PER  = 3'd1;
  localparam logic [2:0] ST_REM  = 3'd2;
  localparam logic [2:0] ST_TMP  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [7:0]       tempo_r, tempo_nxt;
  logic             run_r, run_nxt;
  logic [31:0]      nbt_r, nbt_nxt;
  logic [31:0]      flash_r, flash_nxt;
  logic [31:0]      lrt_r, lrt_nxt;
  logic [15:0]      fd_r, ri_r;
  logic [31:0]      now_r, now_nxt;
  logic             beat_r, beat_nxt;
  logic [PER_W-1:0] per_r, per_nxt;
  logic             ov_r, ov_nxt;
  logic             ob_r, ob_nxt;
  logic             orp_r, orp_nxt;
  logic             orun_r, orun_nxt;
  logic [7:0]       otmp_r, otmp_nxt;
  logic signed [10:0] tsum;
  logic [7:0]       tclamp;
  logic [31:0]      fd_ext;
  logic             repaint;
  div_req_t         dreq;
  div_rsp_t         drsp;

  mbs_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign fd_ext   = {16'b0, fd_r};

  // Clamp the adjusted tempo to its legal range
  always_comb begin
    tsum = $signed({3'b000, tempo_r}) + $signed({{2{in_tempo_delta[8]}}, in_tempo_delta});
    if (tsum < $signed({3'b000, TEMPO_MIN})) begin
      tclamp = TEMPO_MIN;
    end else if (tsum > $signed({3'b000, TEMPO_MAX})) begin
      tclamp = TEMPO_MAX;
    end else begin
      tclamp = tsum[7:0];
    end
  end

  // Repaint request on the state after the event
  always_comb begin
    if (!run_r) begin
      repaint = (now_r < flash_r);
    end else begin
      repaint = (now_r < flash_r) || (lrt_r == '0) ||
                ((now_r - lrt_r) >= {16'b0, ri_r});
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    tempo_nxt = tempo_r;
    run_nxt   = run_r;
    nbt_nxt   = nbt_r;
    flash_nxt = flash_r;
    lrt_nxt   = lrt_r;
    now_nxt   = now_r;
    beat_nxt  = beat_r;
    per_nxt   = per_r;
    ov_nxt    = ov_r && !out_ready;
    ob_nxt    = ob_r;
    orp_nxt   = orp_r;
    orun_nxt  = orun_r;
    otmp_nxt  = otmp_r;
    dreq      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          now_nxt   = in_now_ms;
          beat_nxt  = 1'b0;
          state_nxt = ST_EMIT;
          case (in_kind)
            KIND_TICK: begin
              if (run_r) begin
                if (nbt_r == '0) begin
                  nbt_nxt   = in_now_ms;
                  flash_nxt = in_now_ms + fd_ext;
                  beat_nxt  = 1'b1;
                end else if (in_now_ms >= nbt_r) begin
                  dreq.start    = 1'b1;
                  dreq.dividend = MS_PER_MINUTE;
                  dreq.divisor  = {3'b000, tempo_r};
                  state_nxt     = ST_PER;
                end
              end
            end
            KIND_TOGGLE: begin
              run_nxt = !run_r;
              if (!run_r) begin
                nbt_nxt   = in_now_ms;
                flash_nxt = in_now_ms + fd_ext;
              end else begin
                nbt_nxt = '0;
              end
            end
            KIND_TEMPO: begin
              tempo_nxt = tclamp;
              if (run_r) begin
                dreq.start    = 1'b1;
                dreq.dividend = MS_PER_MINUTE;
                dreq.divisor  = {3'b000, tclamp};
                state_nxt     = ST_TMP;
              end
            end
            KIND_LEAVE:   run_nxt = 1'b0;
            KIND_REPAINT: lrt_nxt = in_now_ms;
            default: ;
          endcase
        end
      end
      ST_PER: begin
        // Period known: divide the lateness by it
        if (drsp.done) begin
          per_nxt       = drsp.quotient[PER_W-1:0];
          dreq.start    = 1'b1;
          dreq.dividend = now_r - nbt_r;
          dreq.divisor  = drsp.quotient[PER_W-1:0];
          state_nxt     = ST_REM;
        end
      end
      ST_REM: begin
        // Advance past now: now - (late mod period) + period
        if (drsp.done) begin
          nbt_nxt   = now_r - {21'b0, drsp.remainder} + {21'b0, per_r};
          flash_nxt = now_r + fd_ext;
          beat_nxt  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_TMP: begin
        if (drsp.done) begin
          nbt_nxt   = now_r + {21'b0, drsp.quotient[PER_W-1:0]};
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Load the result register once it is free
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          ob_nxt    = beat_r;
          orp_nxt   = repaint;
          orun_nxt  = run_r;
          otmp_nxt  = tempo_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tempo_r <= TEMPO_RESET;
      run_r   <= 1'b0;
      nbt_r   <= '0;
      flash_r <= '0;
      lrt_r   <= '0;
      ov_r    <= 1'b0;
      fd_r    <= FLASH_RESET;
      ri_r    <= REPAINT_RESET;
    end else begin
      state_r <= state_nxt;
      tempo_r <= tempo_nxt;
      run_r   <= run_nxt;
      nbt_r   <= nbt_nxt;
      flash_r <= flash_nxt;
      lrt_r   <= lrt_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FLASH:   fd_r <= cfg_wdata;
          CFG_REPAINT: ri_r <= cfg_wdata;
        endcase
      end
    end
    now_r  <= now_nxt;
    beat_r <= beat_nxt;
    per_r  <= per_nxt;
    ob_r   <= ob_nxt;
    orp_r  <= orp_nxt;
    orun_r <= orun_nxt;
    otmp_r <= otmp_nxt;
  end

  assign out_valid         = ov_r;
  assign out_beat          = ob_r;
  assign out_wants_repaint = orp_r;
  assign out_running       = orun_r;
  assign out_tempo_bpm     = otmp_r;

endmodule

[sv/mbs_div.sv]
// Shared radix-2 restoring divider, one quotient bit per cycle.
module mbs_div
  import mbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [PER_W-1:0] rem_r, rem_nxt;
  logic [PER_W-1:0] dsr_r, dsr_nxt;
  logic [PER_W:0]   shifted;
  logic [PER_W:0]   diff;
  logic             fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted  = {rem_r, quo_r[DIV_W-1]};
    diff     = shifted - {1'b0, dsr_r};
    fits     = (shifted >= {1'b0, dsr_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      rem_nxt = fits ? diff[PER_W-1:0] : shifted[PER_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule
